FILE: design/timed_event_priority_queue_core_defines.svh
// Assertion macros for the timed event priority queue core.
`ifndef TIMED_EVENT_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define TIMED_EVENT_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TEPQ_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TEPQ_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/tepq_pkg.sv
// ----------------------------------------------------------------------------
// tepq_pkg
// Types and constants shared by the timed event priority queue core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tepq_pkg;

    localparam int EVENTS_DEF          = 16;
    localparam int CYCLES_PER_LINE_DEF = 227;
    localparam int ID_W                = 4;
    localparam int IDS                 = 1 << ID_W;
    localparam int CYC_W               = 32;
    localparam int PRI_W               = 8;
    localparam int POS_W               = 10;
    localparam int QCNT_W              = 5;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_POP    = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_POPPED  = 2'd1,
        ST_NOT_DUE = 2'd2,
        ST_IGNORED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic pop_hit;
        logic div_done;
    } t_stat;

endpackage

FILE: design/tepq_if.sv
// ----------------------------------------------------------------------------
// tepq_req_if / tepq_rsp_if
// Valid/ready channels for queue requests and responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tepq_req_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       func;
    logic [tepq_pkg::ID_W-1:0]        event_id;
    logic [tepq_pkg::CYC_W-1:0]       event_cycle;
    logic [tepq_pkg::PRI_W-1:0]       event_priority;
    logic [tepq_pkg::CYC_W-1:0]       limit_cycle;

    modport source (output valid, func, event_id, event_cycle, event_priority,
                    limit_cycle, input ready);
    modport sink   (input valid, func, event_id, event_cycle, event_priority,
                    limit_cycle, output ready);
endinterface

interface tepq_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [tepq_pkg::ID_W-1:0]        out_event_id;
    logic [tepq_pkg::CYC_W-1:0]       out_cycle;
    logic [tepq_pkg::CYC_W-1:0]       out_line;
    logic [tepq_pkg::POS_W-1:0]       out_position;
    logic [tepq_pkg::QCNT_W-1:0]      queued_count;

    modport source (output valid, status, out_event_id, out_cycle, out_line,
                    out_position, queued_count, input ready);
    modport sink   (input valid, status, out_event_id, out_cycle, out_line,
                    out_position, queued_count, output ready);
endinterface

FILE: design/tepq_div.sv
// ----------------------------------------------------------------------------
// tepq_div
// Division by a constant through reciprocal multiplication: low partial product, then quotient, then remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tepq_div #(
    parameter int DIVISOR = tepq_pkg::CYCLES_PER_LINE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tepq_pkg::CYC_W-1:0]    i_dividend,
    output logic                          o_done,
    output logic [tepq_pkg::CYC_W-1:0]    o_quot,
    output logic [tepq_pkg::POS_W-1:0]    o_rem
);

    localparam int MW    = tepq_pkg::CYC_W + 1;
    localparam int LO_W  = tepq_pkg::CYC_W / 2;
    localparam int HI_W  = MW - LO_W;
    localparam int PW    = tepq_pkg::CYC_W + MW;
    localparam int DW    = tepq_pkg::POS_W + 1;
    localparam int SHIFT = tepq_pkg::CYC_W + $clog2(DIVISOR);
    localparam longint unsigned MAGIC =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [MW-1:0]   MAGIC_V  = MW'(MAGIC);
    localparam logic [LO_W-1:0] MAGIC_LO = MAGIC_V[LO_W-1:0];
    localparam logic [HI_W-1:0] MAGIC_HI = MAGIC_V[MW-1:LO_W];
    localparam logic [DW-1:0]   DIV_V    = DW'(DIVISOR);

    logic [tepq_pkg::CYC_W-1:0]      r_x;
    logic [tepq_pkg::CYC_W+LO_W-1:0] r_plo;
    logic [tepq_pkg::CYC_W-1:0]      r_quot;
    logic [tepq_pkg::POS_W-1:0]      r_rem;
    logic [2:0]                      r_stg;
    logic                            r_done;
    logic [tepq_pkg::CYC_W+HI_W-1:0] w_phi;
    logic [PW-1:0]                   w_prod;
    logic [PW-1:0]                   w_sh;
    logic [tepq_pkg::CYC_W+DW-1:0]   w_qd;
    logic [tepq_pkg::CYC_W-1:0]      w_diff;

    assign w_phi  = r_x * MAGIC_HI;
    assign w_prod = {w_phi, {LO_W{1'b0}}} + PW'(r_plo);
    assign w_sh   = w_prod >> SHIFT;
    assign w_qd   = r_quot * DIV_V;
    assign w_diff = r_x - w_qd[tepq_pkg::CYC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg  <= '0;
            r_done <= 1'b0;
        end else begin
            r_stg  <= {r_stg[1:0], i_start};
            r_done <= r_stg[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dividend;
        end
        if (r_stg[0]) begin
            r_plo <= r_x * MAGIC_LO;
        end
        if (r_stg[1]) begin
            r_quot <= w_sh[tepq_pkg::CYC_W-1:0];
        end
        if (r_stg[2]) begin
            r_rem <= w_diff[tepq_pkg::POS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

FILE: design/tepq_dpath.sv
// ----------------------------------------------------------------------------
// tepq_dpath
// Shift-register sorted queue, presence flags and response registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timed_event_priority_queue_core_defines.svh"

module tepq_dpath #(
    parameter int EVENTS          = tepq_pkg::EVENTS_DEF,
    parameter int CYCLES_PER_LINE = tepq_pkg::CYCLES_PER_LINE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tepq_pkg::t_cmd                i_cmd,
    output tepq_pkg::t_stat               o_stat,
    input  logic [1:0]                    i_func,
    input  logic [tepq_pkg::ID_W-1:0]     i_event_id,
    input  logic [tepq_pkg::CYC_W-1:0]    i_event_cycle,
    input  logic [tepq_pkg::PRI_W-1:0]    i_event_priority,
    input  logic [tepq_pkg::CYC_W-1:0]    i_limit_cycle,
    output logic [1:0]                    o_status,
    output logic [tepq_pkg::ID_W-1:0]     o_event_id,
    output logic [tepq_pkg::CYC_W-1:0]    o_cycle,
    output logic [tepq_pkg::CYC_W-1:0]    o_line,
    output logic [tepq_pkg::POS_W-1:0]    o_position,
    output logic [tepq_pkg::QCNT_W-1:0]   o_queued_count
);

    localparam int CW = $clog2(EVENTS + 1);

    logic [1:0]                   r_func;
    logic [tepq_pkg::ID_W-1:0]    r_id;
    logic [tepq_pkg::CYC_W-1:0]   r_cyc;
    logic [tepq_pkg::PRI_W-1:0]   r_pri;
    logic [tepq_pkg::CYC_W-1:0]   r_lim;

    logic [tepq_pkg::ID_W-1:0]    r_ids  [EVENTS];
    logic [tepq_pkg::CYC_W-1:0]   r_cycs [EVENTS];
    logic [tepq_pkg::PRI_W-1:0]   r_pris [EVENTS];
    logic [tepq_pkg::ID_W-1:0]    n_ids  [EVENTS];
    logic [tepq_pkg::CYC_W-1:0]   n_cycs [EVENTS];
    logic [tepq_pkg::PRI_W-1:0]   n_pris [EVENTS];
    logic [CW-1:0]                r_count, n_count;
    logic [tepq_pkg::IDS-1:0]     r_flags, n_flags;

    logic [1:0]                   r_status, n_status;
    logic [tepq_pkg::ID_W-1:0]    r_oid, n_oid;
    logic [tepq_pkg::CYC_W-1:0]   r_ocyc, n_ocyc;
    logic [tepq_pkg::CYC_W-1:0]   r_line;
    logic [tepq_pkg::POS_W-1:0]   r_pos;
    logic [tepq_pkg::QCNT_W-1:0]  r_qcount;

    logic [EVENTS-1:0]            w_place;
    logic [EVENTS-1:0]            w_shift;
    logic                         w_pop_hit;
    logic                         w_div_done;
    logic [tepq_pkg::CYC_W-1:0]   w_quot;
    logic [tepq_pkg::POS_W-1:0]   w_rem;
    logic [CW+tepq_pkg::QCNT_W-1:0] w_qext;

    assign w_pop_hit = (r_count != '0) && (r_cycs[0] <= r_lim);

    always_comb begin
        for (int i = 0; i < EVENTS; i++) begin
            if (CW'(i) >= r_count) begin
                w_place[i] = 1'b1;
            end else begin
                w_place[i] = (r_cyc < r_cycs[i]) ||
                             ((r_cyc == r_cycs[i]) && (r_pri > r_pris[i]));
            end
        end
        for (int i = 0; i < EVENTS; i++) begin
            if (r_func == tepq_pkg::FUNC_POP) begin
                w_shift[i] = 1'b1;
            end else begin
                w_shift[i] = (CW'(i) < r_count) && (r_ids[i] == r_id);
                if (i > 0) begin
                    w_shift[i] = w_shift[i] | w_shift[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    always_comb begin
        n_ids    = r_ids;
        n_cycs   = r_cycs;
        n_pris   = r_pris;
        n_count  = r_count;
        n_flags  = r_flags;
        n_status = tepq_pkg::ST_DONE;
        n_oid    = '0;
        n_ocyc   = '0;
        case (tepq_pkg::t_func'(r_func)) inside
            tepq_pkg::FUNC_INSERT: begin
                if (r_flags[r_id] || (r_count == CW'(EVENTS))) begin
                    n_status = tepq_pkg::ST_IGNORED;
                end else begin
                    for (int i = 0; i < EVENTS; i++) begin
                        if (w_place[i] && ((i == 0) || !w_place[(i == 0) ? 0 : i-1])) begin
                            n_ids[i]  = r_id;
                            n_cycs[i] = r_cyc;
                            n_pris[i] = r_pri;
                        end else if ((i > 0) && w_place[(i == 0) ? 0 : i-1]) begin
                            n_ids[i]  = r_ids[(i == 0) ? 0 : i-1];
                            n_cycs[i] = r_cycs[(i == 0) ? 0 : i-1];
                            n_pris[i] = r_pris[(i == 0) ? 0 : i-1];
                        end
                    end
                    n_count        = r_count + CW'(1);
                    n_flags[r_id]  = 1'b1;
                end
            end
            tepq_pkg::FUNC_REMOVE, tepq_pkg::FUNC_POP: begin
                if ((r_func == tepq_pkg::FUNC_POP) && !w_pop_hit) begin
                    n_status = tepq_pkg::ST_NOT_DUE;
                end else if ((r_func == tepq_pkg::FUNC_POP) || r_flags[r_id]) begin
                    for (int i = 0; i < EVENTS - 1; i++) begin
                        if (w_shift[i]) begin
                            n_ids[i]  = r_ids[i+1];
                            n_cycs[i] = r_cycs[i+1];
                            n_pris[i] = r_pris[i+1];
                        end
                    end
                    n_count = r_count - CW'(1);
                    if (r_func == tepq_pkg::FUNC_POP) begin
                        n_flags[r_ids[0]] = 1'b0;
                        n_status          = tepq_pkg::ST_POPPED;
                        n_oid             = r_ids[0];
                        n_ocyc            = r_cycs[0];
                    end else begin
                        n_flags[r_id] = 1'b0;
                    end
                end
            end
            default: begin
                n_count = '0;
                n_flags = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_flags <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_id   <= i_event_id;
            r_cyc  <= i_event_cycle;
            r_pri  <= i_event_priority;
            r_lim  <= i_limit_cycle;
        end
        if (i_cmd.exec) begin
            r_ids    <= n_ids;
            r_cycs   <= n_cycs;
            r_pris   <= n_pris;
            r_status <= n_status;
            r_oid    <= n_oid;
            r_ocyc   <= n_ocyc;
            r_line   <= '0;
            r_pos    <= '0;
            r_qcount <= w_qext[tepq_pkg::QCNT_W-1:0];
        end else if (w_div_done) begin
            r_line <= w_quot;
            r_pos  <= w_rem;
        end
    end

    assign w_qext = {{tepq_pkg::QCNT_W{1'b0}}, n_count};

    tepq_div #(
        .DIVISOR (CYCLES_PER_LINE)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.exec && (r_func == tepq_pkg::FUNC_POP) && w_pop_hit),
        .i_dividend (r_cycs[0]),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign o_stat.pop_hit  = (r_func == tepq_pkg::FUNC_POP) && w_pop_hit;
    assign o_stat.div_done = w_div_done;
    assign o_status        = r_status;
    assign o_event_id      = r_oid;
    assign o_cycle         = r_ocyc;
    assign o_line          = r_line;
    assign o_position      = r_pos;
    assign o_queued_count  = r_qcount;

    `TEPQ_ASSERT_IMP(a_count_flags, 1'b1, $countones(r_flags) == int'(r_count),
                     "count and flags differ")
    `TEPQ_ASSERT_IMP(a_count_max, 1'b1, r_count <= CW'(EVENTS), "queue count beyond depth")
    `TEPQ_ASSERT_NXT(a_pop_drop, i_cmd.exec && o_stat.pop_hit,
                     r_count == $past(r_count) - CW'(1), "pop did not drop an entry")

endmodule

FILE: design/tepq_ctrl.sv
// ----------------------------------------------------------------------------
// tepq_ctrl
// Sequencer: accept a request, execute it, wait for the divider after a successful pop, respond.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "timed_event_priority_queue_core_defines.svh"

module tepq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tepq_pkg::t_cmd      o_cmd,
    input  tepq_pkg::t_stat     i_stat
);

    tepq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tepq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            tepq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tepq_pkg::S_EXEC;
                end
            end
            tepq_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_stat.pop_hit ? tepq_pkg::S_DIV : tepq_pkg::S_OUT;
            end
            tepq_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = tepq_pkg::S_OUT;
                end
            end
            tepq_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = tepq_pkg::S_IDLE;
                end
            end
            default: n_state = tepq_pkg::S_IDLE;
        endcase
    end

    `TEPQ_ASSERT_IMP(a_one_side, 1'b1, !(o_in_ready && o_out_valid), "accept during response")
    `TEPQ_ASSERT_NXT(a_load_exec, o_cmd.load, o_cmd.exec, "load not followed by execute")

endmodule

FILE: design/timed_event_priority_queue_core.sv
// Insert, remove, clear and a pop that finds nothing due go from accept through
// execute to the response; a successful pop also waits for the line and
// position from the reciprocal-multiply divider. One transaction at a time.
// A new transaction is accepted only after the sink has taken the response.
// Reset: synchronous active low; empties the queue, no clearing pass.
// ----------------------------------------------------------------------------
// timed_event_priority_queue_core
// Sorted event queue ordered by due cycle, then priority, then arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_event_priority_queue_core #(
    parameter int EVENTS          = tepq_pkg::EVENTS_DEF,
    parameter int CYCLES_PER_LINE = tepq_pkg::CYCLES_PER_LINE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tepq_req_if.sink    i_req,
    tepq_rsp_if.source  o_rsp
);

    tepq_pkg::t_cmd  w_cmd;
    tepq_pkg::t_stat w_stat;

    tepq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    tepq_dpath #(
        .EVENTS          (EVENTS),
        .CYCLES_PER_LINE (CYCLES_PER_LINE)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_func           (i_req.func),
        .i_event_id       (i_req.event_id),
        .i_event_cycle    (i_req.event_cycle),
        .i_event_priority (i_req.event_priority),
        .i_limit_cycle    (i_req.limit_cycle),
        .o_status         (o_rsp.status),
        .o_event_id       (o_rsp.out_event_id),
        .o_cycle          (o_rsp.out_cycle),
        .o_line           (o_rsp.out_line),
        .o_position       (o_rsp.out_position),
        .o_queued_count   (o_rsp.queued_count)
    );

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// Timed event priority queue core testbench
// Drives insert, remove, pop and clear transactions with random idling on
// both channels. A behavioral sorted queue predicts every response, and a
// scoreboard class checks the responses in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int NEV = 16;
    localparam int CPL = 227;
    localparam longint MAX_CYCLES = 2000000;

    typedef struct packed {
        tepq_pkg::t_status status;
        logic [3:0]  id;
        logic [31:0] cyc;
        logic [31:0] line;
        logic [9:0]  pos;
        logic [4:0]  count;
    } t_resp;

    int errors = 0;

    task automatic report(input string msg);
        $display("MISMATCH %0t: %s", $time, msg);
        errors++;
    endtask

    class resp_board;
        t_resp pending[$];
        int    checked;

        function void note(input t_resp r);
            pending.push_back(r);
        endfunction

        task check(input t_resp got);
            t_resp w;
            if (pending.size() == 0) begin
                report($sformatf("unexpected response %p", got));
                return;
            end
            w = pending.pop_front();
            checked++;
            if (got.status !== w.status)
                report($sformatf("status %0d want %0d", got.status, w.status));
            if (got.id !== w.id) report($sformatf("id %0d want %0d", got.id, w.id));
            if (got.cyc !== w.cyc) report($sformatf("cycle %0d want %0d", got.cyc, w.cyc));
            if (got.line !== w.line)
                report($sformatf("line %0d want %0d", got.line, w.line));
            if (got.pos !== w.pos) report($sformatf("pos %0d want %0d", got.pos, w.pos));
            if (got.count !== w.count)
                report($sformatf("count %0d want %0d", got.count, w.count));
        endtask
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    tepq_req_if req();
    tepq_rsp_if rsp();

    timed_event_priority_queue_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req.sink), .o_rsp(rsp.source)
    );

    initial forever #4 i_clk = ~i_clk;

    // sorted queue shadow
    logic [3:0]  q_id[$];
    logic [31:0] q_cyc[$];
    logic [7:0]  q_pri[$];
    logic [15:0] q_flags = '0;

    function automatic t_resp predict(input tepq_pkg::t_func f, input logic [3:0] id,
                                      input logic [31:0] cyc, input logic [7:0] pri,
                                      input logic [31:0] lim);
        t_resp r;
        int    slot;
        r = '0;
        r.status = tepq_pkg::ST_DONE;
        case (f)
            tepq_pkg::FUNC_INSERT: begin
                if (q_flags[id] || q_id.size() >= NEV) begin
                    r.status = tepq_pkg::ST_IGNORED;
                end else begin
                    slot = q_id.size();
                    for (int i = 0; i < q_id.size(); i++)
                        if (cyc < q_cyc[i] || (cyc == q_cyc[i] && pri > q_pri[i])) begin
                            slot = i;
                            break;
                        end
                    q_id.insert(slot, id);
                    q_cyc.insert(slot, cyc);
                    q_pri.insert(slot, pri);
                    q_flags[id] = 1'b1;
                end
            end
            tepq_pkg::FUNC_REMOVE: begin
                if (q_flags[id]) begin
                    for (int i = 0; i < q_id.size(); i++)
                        if (q_id[i] == id) begin
                            q_id.delete(i);
                            q_cyc.delete(i);
                            q_pri.delete(i);
                            break;
                        end
                    q_flags[id] = 1'b0;
                end
            end
            tepq_pkg::FUNC_POP: begin
                if (q_id.size() > 0 && q_cyc[0] <= lim) begin
                    r.status = tepq_pkg::ST_POPPED;
                    r.id = q_id.pop_front();
                    r.cyc = q_cyc.pop_front();
                    void'(q_pri.pop_front());
                    q_flags[r.id] = 1'b0;
                    r.line = r.cyc / CPL;
                    r.pos = 10'(r.cyc % CPL);
                end else begin
                    r.status = tepq_pkg::ST_NOT_DUE;
                end
            end
            default: begin
                q_id.delete();
                q_cyc.delete();
                q_pri.delete();
                q_flags = '0;
            end
        endcase
        r.count = 5'(q_id.size());
        return r;
    endfunction

    resp_board board = new();
    int src_idle_pct = 31;
    int snk_idle_pct = 48;
    longint cycle_cnt = 0;
    int n_pops = 0;
    int n_ign = 0;

    initial begin
        req.valid = 0;
        req.func = tepq_pkg::FUNC_CLEAR;
        req.event_id = '0;
        req.event_cycle = '0;
        req.event_priority = '0;
        req.limit_cycle = '0;
        rsp.ready = 0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // response side
    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready) begin
            board.check({tepq_pkg::t_status'(rsp.status), rsp.out_event_id, rsp.out_cycle,
                         rsp.out_line, rsp.out_position, rsp.queued_count});
        end
        if (i_rst_n) rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic send(input tepq_pkg::t_func f, input logic [3:0] id,
                        input logic [31:0] cyc, input logic [7:0] pri,
                        input logic [31:0] lim);
        t_resp r;
        while ($urandom_range(99) < src_idle_pct) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.func <= f;
        req.event_id <= id;
        req.event_cycle <= cyc;
        req.event_priority <= pri;
        req.limit_cycle <= lim;
        @(posedge i_clk);
        while (!req.ready) @(posedge i_clk);
        r = predict(f, id, cyc, pri, lim);
        if (r.status == tepq_pkg::ST_POPPED) n_pops++;
        if (r.status == tepq_pkg::ST_IGNORED) n_ign++;
        board.note(r);
    endtask

    task automatic random_item();
        int          k;
        logic [31:0] base;
        k = $urandom_range(99);
        base = ($urandom_range(3) == 0) ? $urandom() : $urandom_range(2000);
        if (k < 45)
            send(tepq_pkg::FUNC_INSERT, 4'($urandom_range(15)), base,
                 ($urandom_range(2) == 0) ? 8'd5 : 8'($urandom()), $urandom());
        else if (k < 55)
            send(tepq_pkg::FUNC_REMOVE, 4'($urandom_range(15)), $urandom(),
                 8'($urandom()), $urandom());
        else if (k < 97)
            send(tepq_pkg::FUNC_POP, 4'($urandom()), $urandom(), 8'($urandom()),
                 ($urandom_range(4) == 0) ? $urandom() : base);
        else
            send(tepq_pkg::FUNC_CLEAR, 4'($urandom()), $urandom(), 8'($urandom()),
                 $urandom());
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed
        send(tepq_pkg::FUNC_POP, 4'd0, 32'd0, 8'd0, 32'hFFFF_FFFF);
        send(tepq_pkg::FUNC_REMOVE, 4'd3, 32'd0, 8'd0, 32'd0);
        send(tepq_pkg::FUNC_INSERT, 4'd0, 32'hFFFF_FFFF, 8'd0, 32'd0);
        send(tepq_pkg::FUNC_INSERT, 4'd15, 32'd0, 8'd255, 32'd0);
        send(tepq_pkg::FUNC_INSERT, 4'd15, 32'd7, 8'd1, 32'd0);
        send(tepq_pkg::FUNC_INSERT, 4'd1, 32'd100, 8'd10, 32'd0);
        send(tepq_pkg::FUNC_INSERT, 4'd2, 32'd100, 8'd20, 32'd0);
        send(tepq_pkg::FUNC_INSERT, 4'd3, 32'd100, 8'd20, 32'd0);
        send(tepq_pkg::FUNC_POP, 4'd0, 32'd0, 8'd0, 32'd0);
        send(tepq_pkg::FUNC_POP, 4'd0, 32'd0, 8'd0, 32'd99);
        send(tepq_pkg::FUNC_REMOVE, 4'd2, 32'd0, 8'd0, 32'd0);
        send(tepq_pkg::FUNC_POP, 4'd0, 32'd0, 8'd0, 32'd100);
        send(tepq_pkg::FUNC_CLEAR, 4'd0, 32'd0, 8'd0, 32'd0);
        for (int i = 0; i < 17; i++)
            send(tepq_pkg::FUNC_INSERT, 4'(i), 32'(32'hFFFF_FFF0 + i), 8'($urandom()),
                 32'd0);
        send(tepq_pkg::FUNC_POP, 4'd0, 32'd0, 8'd0, 32'hFFFF_FFFF);
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 31 : (ph == 1) ? 48 : 0;
            snk_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 31 : 0;
            repeat (460) random_item();
        end
        req.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Checked %0d responses: %0d pops, %0d ignored inserts.",
                 board.checked, n_pops, n_ign);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+design
design/tepq_pkg.sv
design/tepq_if.sv
design/tepq_div.sv
design/tepq_dpath.sv
design/tepq_ctrl.sv
design/timed_event_priority_queue_core.sv
test/tb.sv
